/* rtl/integer_to_digit_string_core_defines.svh */
// assertion macros for the integer to digit string core
`ifndef INTEGER_TO_DIGIT_STRING_CORE_DEFINES_SVH
`define INTEGER_TO_DIGIT_STRING_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ITDS_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ITDS_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/itds_pkg.sv */
// package: types, constants and helper functions for the digit string core
package itds_pkg;

	localparam int unsigned VALUE_PORT_W = 32;
	localparam int unsigned RADIX_W      = 6;
	localparam int unsigned DIGIT_W      = 6;
	localparam int unsigned CHAR_W       = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [DIGIT_W-1:0] DEC_MAX     = 6'd9;
	localparam logic [DIGIT_W-1:0] DEC_BASE    = 6'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0]  ASCII_LC_A  = 7'h61;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_OUT
	} state_t;

	// clamp the programmed base into 2..36
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN)
			res = RADIX_MIN;
		else if (r > RADIX_MAX)
			res = RADIX_MAX;
		else
			res = r;
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d > DEC_MAX)
			res = CHAR_W'(d - DEC_BASE) + ASCII_LC_A;
		else
			res = CHAR_W'(d) + ASCII_ZERO;
		return res;
	endfunction

endpackage

/* rtl/integer_to_digit_string_core.sv */
// each digit costs one pass of the bit-serial divider, followed by a hand-over
// characters leave one beat per pass through the read and output states, read back from the digit store
// busy drops with the last beat; the core takes no new value until then
// reset: radix returns to 10, the sequencer idles and no strobe is raised
// the receiver takes every beat as it comes; there is no back-pressure
`include "integer_to_digit_string_core_defines.svh"

module integer_to_digit_string_core
	import itds_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [VALUE_PORT_W-1:0] value,
	input  logic                    radix_we,
	input  logic [RADIX_W-1:0]      radix_wdata,
	output logic                    strobe,
	output logic [CHAR_W-1:0]       digit_char,
	output logic                    last_digit
);

	localparam int unsigned ADDR_W = $clog2(VALUE_WIDTH);
	localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);

	state_t state_q, state_nxt;

	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     base_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_m1;
	logic                   strobe_q;
	logic                   last_q;
	logic [CHAR_W-1:0]      char_q;

	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [VALUE_WIDTH-1:0] div_quot;
	logic [DIGIT_W-1:0]     div_rem;
	logic                   div_done;
	logic                   push;
	logic [DIGIT_W-1:0]     rd_digit;

	itds_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (base_q),
		.quotient (div_quot),
		.remainder(div_rem),
		.done     (div_done)
	);

	assign count_m1 = count_q - CNT_W'(1);

	itds_digit_stack #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_stack (
		.clk  (clk),
		.push (push),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(div_rem),
		.raddr(count_m1[ADDR_W-1:0]),
		.rdata(rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= RADIX_RESET;
		else if (radix_we)
			radix_q <= radix_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt    = state_q;
		div_start    = 1'b0;
		push         = 1'b0;
		div_dividend = div_quot;
		unique case (state_q)
			ST_IDLE: begin
				div_dividend = VALUE_WIDTH'(value);
				if (start) begin
					div_start = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				// zero still yields one digit, so the loop checks after the divide
				if (div_done) begin
					push = 1'b1;
					if (div_quot == '0)
						state_nxt = ST_RD;
					else
						div_start = 1'b1;
				end
			end
			ST_RD: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (count_q == CNT_W'(1))
					state_nxt = ST_IDLE;
				else
					state_nxt = ST_RD;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			if (state_q == ST_IDLE && start)
				count_q <= '0;
			else if (push)
				count_q <= count_q + CNT_W'(1);
			else if (state_q == ST_OUT) begin
				count_q  <= count_m1;
				strobe_q <= 1'b1;
				last_q   <= (count_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start)
			base_q <= eff_radix(radix_q);
		if (state_q == ST_OUT)
			char_q <= digit_ascii(rd_digit);
	end

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = strobe_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

	`ITDS_ASSERT_NOW(a_strobe_after_busy, clk, arst_n, strobe, $past(busy),
		"character beat without a conversion in progress")
	`ITDS_ASSERT_NOW(a_last_with_strobe, clk, arst_n, last_digit, strobe,
		"last flag raised outside a beat")
	`ITDS_ASSERT_NEXT(a_start_goes_busy, clk, arst_n, start && !busy, busy,
		"accepted value did not start a conversion")
	`ITDS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(VALUE_WIDTH),
		"digit count past the store depth")

endmodule

/* rtl/itds_divider.sv */
// restoring divider, one quotient bit per cycle, small divisor
module itds_divider
	import itds_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [RADIX_W-1:0]     divisor,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [DIGIT_W-1:0]     remainder,
	output logic                   done
);

	localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] dq_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   run_q;
	logic                   done_q;

	logic [DIGIT_W:0]       trial;
	logic [DIGIT_W:0]       diff;
	logic                   ge;
	logic [DIGIT_W-1:0]     rem_nxt;

	// partial remainder stays below the divisor, so six bits plus one shifted in
	always_comb begin
		trial   = {rem_q, dq_q[VALUE_WIDTH-1]};
		ge      = (trial >= {1'b0, divisor});
		diff    = trial - {1'b0, divisor};
		rem_nxt = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(VALUE_WIDTH);
		end else if (run_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dq_q  <= {dq_q[VALUE_WIDTH-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quotient  = dq_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

/* rtl/itds_digit_stack.sv */
// digit store: written least significant first, read back with registered data
module itds_digit_stack
	import itds_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           push,
	input  logic [$clog2(VALUE_WIDTH)-1:0] waddr,
	input  logic [DIGIT_W-1:0]             wdata,
	input  logic [$clog2(VALUE_WIDTH)-1:0] raddr,
	output logic [DIGIT_W-1:0]             rdata
);

	logic [DIGIT_W-1:0] mem [VALUE_WIDTH];
	logic [DIGIT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
